// ===== src/fcsm_pkg.sv =====
// Package: types, constants and helpers for the failsafe command source mux.
`timescale 1ns / 1ps
`default_nettype none

package fcsm_pkg;

  localparam int unsigned AngleW  = 32;
  localparam int unsigned TickW   = 16;
  localparam int unsigned CfgW    = 31;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TickW-1:0] TickMax = {TickW{1'b1}};

  // register indexes
  localparam logic [CfgIdxW-1:0] RegStaleLimit = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStopHold   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegThreshold  = 2'd2;

  localparam logic [TickW-1:0] StaleLimitRst = 16'd38;
  localparam logic [TickW-1:0] StopHoldRst   = 16'd38;
  localparam logic [30:0]      ThresholdRst  = 31'd0;

  typedef enum logic [2:0] {
    OP_TICK       = 3'd0,
    OP_MAN_PAN    = 3'd1,
    OP_MAN_TILT   = 3'd2,
    OP_AUTO_PAN   = 3'd3,
    OP_AUTO_TILT  = 3'd4,
    OP_AUTO_ACT   = 3'd5
  } opcode_e;

  typedef struct packed {
    opcode_e                  opcode;
    logic signed [AngleW-1:0] value;
    logic                     active_flag;
  } in_word_t;

  typedef struct packed {
    logic signed [AngleW-1:0] pan_out;
    logic signed [AngleW-1:0] tilt_out;
    logic                     pan_valid;
    logic                     tilt_valid;
    logic                     auto_selected;
    logic                     timed_out;
  } out_word_t;

  typedef struct packed {
    logic [TickW-1:0] stale_limit;
    logic [TickW-1:0] hold_len;
    logic [30:0]      threshold;
  } cfg_t;

  // |a - b| computed one bit wider so it never wraps
  function automatic logic [AngleW:0] abs_diff(input logic signed [AngleW-1:0] a,
                                               input logic signed [AngleW-1:0] b);
    logic signed [AngleW:0] d;
    d = {a[AngleW-1], a} - {b[AngleW-1], b};
    abs_diff = d[AngleW] ? (~d + 1'b1) : d;
  endfunction

endpackage

`default_nettype wire

// ===== src/failsafe_command_source_mux.sv =====
// Top level of the failsafe command source mux.
`timescale 1ns / 1ps
`default_nettype none

// Picks pan/tilt commands from a manual source (default) or an automatic source
// (while active and fresh, during the stop-hold countdown, or while the post-stop
// hold is set). Opcodes 1-5 update state and produce no word; each tick (opcode 0)
// produces one output word. State updates at the edge that accepts a word, and a
// tick's result is registered at the same edge, so one word per cycle is sustained
// while input is not stalled. A two-entry output buffer (output register plus skid)
// lets one more tick through while the output is stalled; input then stalls until
// the waiting output word is taken. Config writes take effect on the next cycle and
// should be made while the block is idle.
module failsafe_command_source_mux import fcsm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  in_word_t                in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output out_word_t               out_data_o
);

  cfg_t      cfg;
  logic      accept;
  logic      res_valid;
  out_word_t res_word;
  logic      buf_full;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  fcsm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  fcsm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_word_i   (in_data_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res_word)
  );

  fcsm_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_word_i (res_word),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

`ifndef SYNTHESIS
  // input only backs up when a word is already waiting at the output
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // a non-tick word never creates an output word
  a_no_word_from_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.opcode != OP_TICK && !out_valid_o)
      |=> !out_valid_o)
    else $error("output word from non-tick input");

  // a tick accepted into an empty buffer shows up next cycle
  a_tick_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.opcode == OP_TICK && !out_valid_o)
      |=> out_valid_o)
    else $error("tick result missing");
`endif

endmodule

`default_nettype wire

// ===== src/fcsm_cfg.sv =====
// Configuration register file for the failsafe command source mux.
`timescale 1ns / 1ps
`default_nettype none

module fcsm_cfg import fcsm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegStaleLimit: cfg_d.stale_limit = cfg_wdata_i[TickW-1:0];
        RegStopHold:   cfg_d.hold_len    = cfg_wdata_i[TickW-1:0];
        RegThreshold:  cfg_d.threshold   = cfg_wdata_i[30:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stale_limit <= StaleLimitRst;
      cfg_q.hold_len    <= StopHoldRst;
      cfg_q.threshold   <= ThresholdRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== src/fcsm_core.sv =====
// Source state, event decode and tick selection logic.
`timescale 1ns / 1ps
`default_nettype none

module fcsm_core import fcsm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic accept_i,
  input  in_word_t  in_word_i,
  input  cfg_t      cfg_i,
  output logic      res_valid_o,
  output out_word_t res_o
);

  logic signed [AngleW-1:0] man_pan_q, man_pan_d, man_tilt_q, man_tilt_d;
  logic signed [AngleW-1:0] auto_pan_q, auto_pan_d, auto_tilt_q, auto_tilt_d;
  logic [3:0]       have_q, have_d;
  logic             active_q, active_d;
  logic             hold_q, hold_d;
  logic [TickW-1:0] age_q, age_d;
  logic [TickW-1:0] remain_q, remain_d;

  logic             man_slot_have;
  logic signed [AngleW-1:0] man_slot_old;
  logic             man_moved;
  logic [TickW-1:0] age_inc, remain_dec;
  logic             fresh, use_auto, dropped;
  logic             pv, tv;

  // manual write: compare against the slot of the addressed axis
  assign man_slot_old  = (in_word_i.opcode == OP_MAN_PAN) ? man_pan_q : man_tilt_q;
  assign man_slot_have = (in_word_i.opcode == OP_MAN_PAN) ? have_q[0] : have_q[1];
  assign man_moved     = man_slot_have &&
                         (abs_diff(in_word_i.value, man_slot_old) > {2'b00, cfg_i.threshold});

  assign age_inc    = (age_q == TickMax) ? age_q : age_q + 1'b1;
  assign remain_dec = (remain_q != '0) ? remain_q - 1'b1 : remain_q;
  assign fresh      = age_inc <= cfg_i.stale_limit;
  assign use_auto   = (active_q && fresh) || (remain_dec != '0) || hold_q;
  assign dropped    = active_q && !fresh;
  assign pv         = use_auto ? have_q[2] : have_q[0];
  assign tv         = use_auto ? have_q[3] : have_q[1];

  always_comb begin
    man_pan_d   = man_pan_q;
    man_tilt_d  = man_tilt_q;
    auto_pan_d  = auto_pan_q;
    auto_tilt_d = auto_tilt_q;
    have_d      = have_q;
    active_d    = active_q;
    hold_d      = hold_q;
    age_d       = age_q;
    remain_d    = remain_q;
    res_valid_o = 1'b0;
    if (accept_i) begin
      unique case (in_word_i.opcode)
        OP_TICK: begin
          res_valid_o = 1'b1;
          age_d       = age_inc;
          remain_d    = remain_dec;
          if (dropped) begin
            active_d = 1'b0;
            hold_d   = 1'b1;
          end
        end
        OP_MAN_PAN: begin
          if (hold_q && man_moved) hold_d = 1'b0;
          man_pan_d = in_word_i.value;
          have_d[0] = 1'b1;
        end
        OP_MAN_TILT: begin
          if (hold_q && man_moved) hold_d = 1'b0;
          man_tilt_d = in_word_i.value;
          have_d[1]  = 1'b1;
        end
        OP_AUTO_PAN: begin
          auto_pan_d = in_word_i.value;
          have_d[2]  = 1'b1;
          age_d      = '0;
        end
        OP_AUTO_TILT: begin
          auto_tilt_d = in_word_i.value;
          have_d[3]   = 1'b1;
          age_d       = '0;
        end
        OP_AUTO_ACT: begin
          active_d = in_word_i.active_flag;
          if (in_word_i.active_flag) begin
            hold_d = 1'b0;
            age_d  = '0;
          end else begin
            hold_d   = 1'b1;
            remain_d = cfg_i.hold_len;
          end
        end
        default: ;  // unused codes do nothing
      endcase
    end
  end

  always_comb begin
    res_o.pan_out       = pv ? (use_auto ? auto_pan_q : man_pan_q) : '0;
    res_o.tilt_out      = tv ? (use_auto ? auto_tilt_q : man_tilt_q) : '0;
    res_o.pan_valid     = pv;
    res_o.tilt_valid    = tv;
    res_o.auto_selected = use_auto;
    res_o.timed_out     = dropped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      man_pan_q   <= '0;
      man_tilt_q  <= '0;
      auto_pan_q  <= '0;
      auto_tilt_q <= '0;
      have_q      <= '0;
      active_q    <= 1'b0;
      hold_q      <= 1'b0;
      age_q       <= '0;
      remain_q    <= '0;
    end else begin
      man_pan_q   <= man_pan_d;
      man_tilt_q  <= man_tilt_d;
      auto_pan_q  <= auto_pan_d;
      auto_tilt_q <= auto_tilt_d;
      have_q      <= have_d;
      active_q    <= active_d;
      hold_q      <= hold_d;
      age_q       <= age_d;
      remain_q    <= remain_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/fcsm_out_buf.sv =====
// Output register with a skid entry so the input side can push one more word under stall.
`timescale 1ns / 1ps
`default_nettype none

module fcsm_out_buf import fcsm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  out_word_t push_word_i,
  output logic      full_o,
  output logic      out_valid_o,
  output out_word_t out_word_o,
  input  wire logic out_stall_i
);

  logic      out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  out_word_t out_q, out_d, skid_q, skid_d;
  logic      pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // input is stalled; drain skid into the output slot
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = push_word_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_word_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb_failsafe_command_source_mux.sv =====
// Testbench for the failsafe command source mux: directed, episode and random words vs. a local model.
`timescale 1ns / 1ps

module tb_failsafe_command_source_mux;
  import fcsm_pkg::*;

  // opcodes the block must ignore
  localparam logic [2:0] OpSpareLo = 3'd6;
  localparam logic [2:0] OpSpareHi = 3'd7;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 6;
  localparam int RandomWords = 1000;
  localparam int CalmWords   = 250;
  localparam int MaxTicks    = 40;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx   = RegStaleLimit;
  logic [CfgW-1:0]    cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_word_t           in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_word_t          out_data;

  bit no_idle         = 1'b0;
  int mismatch_count  = 0;
  int cycle_count     = 0;
  int words_sent      = 0;

  // local copy of the mux state; index 0 is pan, 1 is tilt
  logic signed [31:0] man_cmd  [2];
  logic signed [31:0] auto_cmd [2];
  bit                 man_have [2];
  bit                 auto_have[2];
  bit                 auto_on;
  bit                 stop_latch;
  logic [TickW-1:0]   auto_age;
  logic [TickW-1:0]   hold_left;
  logic [TickW-1:0]   lim_stale;
  logic [TickW-1:0]   lim_hold;
  logic [30:0]        chg_thresh;

  out_word_t due_words[$];

  failsafe_command_source_mux u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_failsafe_command_source_mux failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(0, 99) < 26);
  end

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("MISMATCH at %0t %s: got %h want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_words
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_words.size() == 0) begin
        note_mismatch("word with none due", out_data.pan_out, '0);
      end else begin
        want = due_words.pop_front();
        if (out_data.pan_out !== want.pan_out)
          note_mismatch("pan_out", out_data.pan_out, want.pan_out);
        if (out_data.tilt_out !== want.tilt_out)
          note_mismatch("tilt_out", out_data.tilt_out, want.tilt_out);
        if (out_data.pan_valid !== want.pan_valid)
          note_mismatch("pan_valid", 32'(out_data.pan_valid), 32'(want.pan_valid));
        if (out_data.tilt_valid !== want.tilt_valid)
          note_mismatch("tilt_valid", 32'(out_data.tilt_valid), 32'(want.tilt_valid));
        if (out_data.auto_selected !== want.auto_selected)
          note_mismatch("auto_selected", 32'(out_data.auto_selected),
                        32'(want.auto_selected));
        if (out_data.timed_out !== want.timed_out)
          note_mismatch("timed_out", 32'(out_data.timed_out), 32'(want.timed_out));
      end
    end
  end

  // apply one accepted word to the local state; a tick queues the selection it yields
  task automatic predict_word(input logic [2:0] op, input logic signed [31:0] val,
                              input bit flag);
    out_word_t w;
    bit        fresh;
    bit        pick_auto;
    bit        dropped;
    int        axis;
    longint    delta;
    axis = (op == OP_MAN_TILT || op == OP_AUTO_TILT) ? 1 : 0;
    case (op)
      OP_MAN_PAN, OP_MAN_TILT: begin
        delta = longint'(val) - longint'(man_cmd[axis]);
        if (delta < 0) delta = -delta;
        if (stop_latch && man_have[axis] && delta > longint'(chg_thresh))
          stop_latch = 1'b0;
        man_cmd[axis]  = val;
        man_have[axis] = 1'b1;
      end
      OP_AUTO_PAN, OP_AUTO_TILT: begin
        auto_cmd[axis]  = val;
        auto_have[axis] = 1'b1;
        auto_age        = '0;
      end
      OP_AUTO_ACT: begin
        auto_on = flag;
        if (flag) begin
          stop_latch = 1'b0;
          auto_age   = '0;
        end else begin
          hold_left  = lim_hold;
          stop_latch = 1'b1;
        end
      end
      OP_TICK: begin
        if (auto_age != TickMax) auto_age = auto_age + 1'b1;
        if (hold_left != 0) hold_left = hold_left - 1'b1;
        fresh     = auto_age <= lim_stale;
        pick_auto = (auto_on && fresh) || hold_left != 0 || stop_latch;
        dropped   = auto_on && !fresh;
        if (dropped) begin
          auto_on    = 1'b0;
          stop_latch = 1'b1;
        end
        w.pan_valid     = pick_auto ? auto_have[0] : man_have[0];
        w.tilt_valid    = pick_auto ? auto_have[1] : man_have[1];
        w.pan_out       = !w.pan_valid ? '0 : pick_auto ? auto_cmd[0] : man_cmd[0];
        w.tilt_out      = !w.tilt_valid ? '0 : pick_auto ? auto_cmd[1] : man_cmd[1];
        w.auto_selected = pick_auto;
        w.timed_out     = dropped;
        due_words.push_back(w);
      end
      default: ;
    endcase
  endtask

  // valid is left high on return; any caller that stops sending lowers it first
  task automatic send_word(input logic [2:0] op, input logic [31:0] val, input bit flag);
    while (!no_idle && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= in_word_t'({op, val, flag});
    do @(posedge clk); while (in_stall);
    predict_word(op, val, flag);
    if (op <= OP_AUTO_ACT) words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic load_settings(input logic [TickW-1:0] stale, input logic [TickW-1:0] hold,
                               input logic [30:0] thr);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= RegStaleLimit;
    cfg_wdata <= CfgW'(stale);
    @(posedge clk);
    cfg_idx   <= RegStopHold;
    cfg_wdata <= CfgW'(hold);
    @(posedge clk);
    cfg_idx   <= RegThreshold;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_we    <= 1'b0;
    lim_stale  = stale;
    lim_hold   = hold;
    chg_thresh = thr;
  endtask

  task automatic pick_settings();
    logic [TickW-1:0] s;
    logic [TickW-1:0] h;
    logic [30:0]      t;
    case ($urandom_range(0, 5))
      0:       s = '0;
      1:       s = TickMax;
      default: s = TickW'($urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 5))
      0:       h = '0;
      1:       h = TickMax;
      default: h = TickW'($urandom_range(1, 12));
    endcase
    case ($urandom_range(0, 5))
      0:       t = '0;
      1:       t = 31'h7FFF_FFFF;
      2, 3:    t = 31'($urandom_range(0, 32'h0003_0000));
      default: t = 31'($urandom());
    endcase
    load_settings(s, h, t);
  endtask

  // angles biased toward the extremes and toward steps right at the change threshold
  function automatic logic [31:0] pick_angle(input int axis, input bit manual);
    logic [31:0] base;
    logic [31:0] step;
    base = manual ? man_cmd[axis] : auto_cmd[axis];
    step = {1'b0, chg_thresh} + $urandom_range(0, 2) - 1;
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom_range(0, 1) ? base + step : base - step;
      4:       return base;
      5:       return $urandom_range(0, 32'h0005_0000) - 32'h0002_8000;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random_word();
    int r;
    int axis;
    r    = $urandom_range(0, 99);
    axis = $urandom_range(0, 1);
    if (r < 45)
      send_word(OP_TICK, $urandom(), 1'($urandom()));
    else if (r < 65)
      send_word(axis ? OP_MAN_TILT : OP_MAN_PAN, pick_angle(axis, 1'b1), 1'($urandom()));
    else if (r < 85)
      send_word(axis ? OP_AUTO_TILT : OP_AUTO_PAN, pick_angle(axis, 1'b0), 1'($urandom()));
    else if (r < 95)
      send_word(OP_AUTO_ACT, $urandom(), 1'($urandom()));
    else
      send_word(axis ? OpSpareHi : OpSpareLo, $urandom(), 1'($urandom()));
  endtask

  task automatic episode_step(input bit feed_auto);
    int r;
    int axis;
    r    = $urandom_range(0, 99);
    axis = $urandom_range(0, 1);
    if (r < 60)
      send_word(OP_TICK, $urandom(), 1'($urandom()));
    else if (r < 85 && feed_auto)
      send_word(axis ? OP_AUTO_TILT : OP_AUTO_PAN, pick_angle(axis, 1'b0), 1'($urandom()));
    else
      send_word(axis ? OP_MAN_TILT : OP_MAN_PAN, pick_angle(axis, 1'b1), 1'($urandom()));
  endtask

  // activate, feed for a while, then stop or starve and run out the hold
  task automatic run_episode();
    int n;
    int k;
    send_word(OP_AUTO_ACT, $urandom(), 1'b1);
    n = $urandom_range(1, 12);
    repeat (n) episode_step(1'b1);
    if ($urandom_range(0, 1)) send_word(OP_AUTO_ACT, $urandom(), 1'b0);
    if (int'(lim_stale) + int'(lim_hold) > 30)
      k = $urandom_range(5, 40);
    else
      k = 2 * (int'(lim_stale) + int'(lim_hold)) + $urandom_range(2, 6);
    repeat (k) episode_step(1'b0);
  endtask

  task automatic test_directed_words();
    send_word(OP_TICK, 32'hFFFF_FFFF, 1'b1);            // nothing written yet
    send_word(OP_MAN_PAN, 32'h7FFF_FFFF, 1'b0);
    send_word(OP_MAN_TILT, 32'h8000_0000, 1'b1);
    send_word(OP_TICK, 32'h0, 1'b0);
    send_word(OP_AUTO_PAN, 32'hFFFF_FFFF, 1'b1);
    send_word(OP_AUTO_TILT, 32'h0, 1'b0);
    send_word(OP_TICK, $urandom(), 1'b0);               // not active: still manual
    send_word(OpSpareLo, $urandom(), 1'b1);
    send_word(OpSpareHi, $urandom(), 1'b0);
    send_word(OP_AUTO_ACT, 32'hFFFF_FFFF, 1'b1);
    send_word(OP_TICK, 32'h7FFF_FFFF, 1'b1);
    send_word(OP_AUTO_ACT, 32'h8000_0000, 1'b0);
    send_word(OP_TICK, $urandom(), 1'b1);
    send_word(OP_MAN_PAN, 32'h7FFF_FFFF, 1'b1);         // zero step keeps the hold
    send_word(OP_MAN_PAN, 32'h8000_0000, 1'b0);         // full-range step clears it
    send_word(OP_TICK, $urandom(), 1'b0);
    send_word(OP_MAN_TILT, 32'h7FFF_FFFF, 1'b0);
    send_word(OP_AUTO_ACT, $urandom(), 1'b1);
    send_word(OP_AUTO_PAN, 32'h0001_0000, 1'b1);
    send_word(OP_TICK, $urandom(), 1'b0);
    send_word(OP_AUTO_ACT, $urandom(), 1'b0);
    send_word(OP_AUTO_ACT, $urandom(), 1'b0);           // repeat reloads the countdown
    send_word(OP_TICK, $urandom(), 1'b1);
  endtask

  task automatic test_register_extremes();
    load_settings('0, '0, '0);
    repeat (3) run_episode();
    load_settings(TickMax, TickMax, 31'h7FFF_FFFF);
    repeat (3) run_episode();
    load_settings(16'd1, 16'd1, 31'd1);
    repeat (3) run_episode();
    load_settings(16'd38, '0, 31'h0001_0000);
    repeat (3) run_episode();
  endtask

  // countdown loaded from the counter maximum, limits at and just under it
  task automatic test_counter_maximum();
    no_idle = 1'b1;
    load_settings(TickMax, TickMax, '0);
    send_word(OP_AUTO_ACT, $urandom(), 1'b0);
    send_word(OP_AUTO_ACT, $urandom(), 1'b1);
    repeat (MaxTicks) send_word(OP_TICK, $urandom(), 1'($urandom()));
    load_settings(TickMax - 1'b1, TickMax, '0);
    send_word(OP_TICK, $urandom(), 1'b0);
    send_word(OP_TICK, $urandom(), 1'b0);
    no_idle = 1'b0;
  endtask

  task automatic test_random_mix();
    int start;
    int next_change;
    start       = words_sent;
    next_change = words_sent + 150;
    no_idle     = 1'b1;
    pick_settings();
    while (words_sent - start < RandomWords) begin
      if (words_sent - start >= CalmWords) no_idle = 1'b0;
      if (words_sent >= next_change) begin
        pick_settings();
        next_change = words_sent + 150;
      end else if ($urandom_range(0, 49) == 0) begin
        wait_idle();
      end
      if ($urandom_range(0, 99) < 85)
        run_episode();
      else
        repeat (5) send_random_word();
    end
  endtask

  initial begin
    man_cmd    = '{default: '0};
    auto_cmd   = '{default: '0};
    man_have   = '{default: 1'b0};
    auto_have  = '{default: 1'b0};
    auto_on    = 1'b0;
    stop_latch = 1'b0;
    auto_age   = '0;
    hold_left  = '0;
    lim_stale  = StaleLimitRst;
    lim_hold   = StopHoldRst;
    chg_thresh = ThresholdRst;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_words();
    test_register_extremes();
    test_counter_maximum();
    test_random_mix();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("tb_failsafe_command_source_mux passed");
    end else begin
      $display("tb_failsafe_command_source_mux failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/fcsm_pkg.sv
src/fcsm_cfg.sv
src/fcsm_core.sv
src/fcsm_out_buf.sv
src/failsafe_command_source_mux.sv
tb/sv/tb_failsafe_command_source_mux.sv
